@@ rtl/core/slps_pkg.sv @@
// Package with shared constants and helper functions for the sorted line prefix search.
`timescale 1ns / 1ps
package slps_pkg;
    localparam int TEXT_DEPTH_DEF = 4096;
    localparam int KEY_DEPTH_DEF  = 64;
    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam logic [2:0] CMD_TEXT      = 3'd0;
    localparam logic [2:0] CMD_KEY       = 3'd1;
    localparam logic [2:0] CMD_SEARCH    = 3'd2;
    localparam logic [2:0] CMD_CLR_KEY   = 3'd3;
    localparam logic [2:0] CMD_CLR_TEXT  = 3'd4;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;
    localparam logic [1:0] REG_FOLD = 2'd0;
    localparam logic [1:0] REG_DICT = 2'd1;
    localparam logic [1:0] REG_TERM = 2'd2;
    localparam int CMP_LESS    = 0;
    localparam int CMP_EQUAL   = 1;
    localparam int CMP_GREATER = 2;

    function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
        if (en && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
        return c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction
endpackage

@@ rtl/core/slps_if.sv @@
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
interface slps_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] data;
    modport source (output valid, cmd, data, input ready);
    modport sink   (input valid, cmd, data, output ready);
endinterface

interface slps_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] match_start;
    logic [12:0] match_end;
    logic [12:0] line_count;
    modport source (output valid, status, match_start, match_end, line_count, input ready);
    modport sink   (input valid, status, match_start, match_end, line_count, output ready);
endinterface

interface slps_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/core/sorted_line_prefix_search.sv @@
// Top level of the sorted line prefix search with its search sequencer.
`timescale 1ns / 1ps
//  Channel  Direction  Word fields
//  i_in     in         cmd, data
//  o_out    out        status, match_start, match_end, line_count
//  i_cfg    in         index, wdata
// Append, clear and unknown words load the result register at the accepting edge.
// A search builds the working key one key byte at a time, then reads the text bytes
// through bisection, linear scan and run counting, with check, use and done states for
// each skip, line compare or end-of-line walk, and the output state S_OUT that loads
// the result. Reset is synchronous and clears lengths, flags and registers, not memories.
// Input is ready only when idle and the result register is empty or being taken.
module sorted_line_prefix_search #(
    parameter int TEXT_DEPTH = slps_pkg::TEXT_DEPTH_DEF,
    parameter int KEY_DEPTH  = slps_pkg::KEY_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    slps_in_if.sink    i_in,
    slps_out_if.source o_out,
    slps_cfg_if.sink   i_cfg
);
    localparam int TW = $clog2(TEXT_DEPTH);
    localparam int KW = ($clog2(KEY_DEPTH) > 0) ? $clog2(KEY_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_KCHK, S_KUSE, S_BMID, S_SCHK, S_SUSE, S_SDONE,
        S_CCHK, S_CUSE, S_CDONE, S_LTOP, S_RTOP, S_ECHK, S_EUSE, S_EDONE, S_OUT
    } t_state;
    typedef enum logic [1:0] { R_BIS, R_LIN, R_RUN } t_ret;
    typedef enum logic [1:0] { C_LESS, C_EQUAL, C_GREATER } t_cmp;

    t_state r_state;
    t_ret   r_ret;
    t_cmp   r_res;
    logic   r_fold, r_dict;
    logic [7:0] r_term;
    logic [TW:0] r_tlen, r_front, r_back, r_p, r_lpos, r_first, r_last, r_count;
    logic [KW:0] r_klen, r_wlen, r_k, r_i;
    logic        r_kclosed;
    logic [7:0]  r_text [TEXT_DEPTH];
    logic [7:0]  r_key  [KEY_DEPTH];
    logic [7:0]  r_work [KEY_DEPTH];
    logic [7:0]  r_tq, r_kq, r_wq;
    logic        r_valid;
    logic [1:0]  r_status;
    logic [11:0] r_ms;
    logic [12:0] r_me, r_lc;
    logic        n_take, n_load;
    logic [TW:0] n_mid;
    logic [7:0]  n_ch, n_kf;

    assign n_take = i_in.valid && i_in.ready;
    assign n_load = (n_take && i_in.cmd != slps_pkg::CMD_SEARCH) || (r_state == S_OUT);
    assign i_in.ready   = (r_state == S_IDLE) && (!r_valid || o_out.ready);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_valid;
    assign o_out.status = r_status;
    assign o_out.match_start = r_ms;
    assign o_out.match_end   = r_me;
    assign o_out.line_count  = r_lc;
    assign n_mid = r_front + ((r_back - r_front) >> 1);
    assign n_ch  = slps_pkg::fold(r_fold, r_tq);
    assign n_kf  = slps_pkg::fold(r_fold, r_kq);

    // Memories: one read address each, registered read data.
    always_ff @(posedge i_clk) begin
        if (n_take && i_in.cmd == slps_pkg::CMD_TEXT && r_tlen < (TW+1)'(TEXT_DEPTH))
            r_text[r_tlen[TW-1:0]] <= i_in.data;
        if (n_take && i_in.cmd == slps_pkg::CMD_KEY && !r_kclosed &&
            i_in.data != 8'd0 && r_klen < (KW+1)'(KEY_DEPTH))
            r_key[r_klen[KW-1:0]] <= i_in.data;
        if (r_state == S_KUSE && (!r_dict || slps_pkg::is_alnum(n_kf)))
            r_work[r_wlen[KW-1:0]] <= n_kf;
        r_tq <= r_text[r_p[TW-1:0]];
        r_kq <= r_key[r_i[KW-1:0]];
        r_wq <= r_work[r_k[KW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= R_BIS; r_res <= C_EQUAL;
            r_valid <= 1'b0; r_status <= slps_pkg::ST_OK;
            r_ms <= '0; r_me <= '0; r_lc <= '0;
            r_fold <= 1'b0; r_dict <= 1'b0; r_term <= 8'd0;
            r_tlen <= '0; r_klen <= '0; r_kclosed <= 1'b0;
            r_front <= '0; r_back <= '0; r_p <= '0; r_lpos <= '0;
            r_first <= '0; r_last <= '0; r_count <= '0;
            r_wlen <= '0; r_k <= '0; r_i <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    slps_pkg::REG_FOLD: r_fold <= i_cfg.wdata[0];
                    slps_pkg::REG_DICT: r_dict <= i_cfg.wdata[0];
                    slps_pkg::REG_TERM: r_term <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (n_load) r_valid <= 1'b1;
            else if (o_out.ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (n_take) begin
                        r_status <= slps_pkg::ST_OK;
                        r_ms <= '0; r_me <= '0; r_lc <= '0;
                        unique case (i_in.cmd)
                            slps_pkg::CMD_TEXT: begin
                                if (r_tlen < (TW+1)'(TEXT_DEPTH)) r_tlen <= r_tlen + 1'b1;
                                else r_status <= slps_pkg::ST_FULL;
                            end
                            slps_pkg::CMD_KEY: begin
                                if (r_kclosed) ;
                                else if (i_in.data == 8'd0) r_kclosed <= 1'b1;
                                else if (r_klen < (KW+1)'(KEY_DEPTH)) r_klen <= r_klen + 1'b1;
                                else r_status <= slps_pkg::ST_FULL;
                            end
                            slps_pkg::CMD_SEARCH: begin
                                r_i <= '0; r_wlen <= '0; r_state <= S_KCHK;
                            end
                            slps_pkg::CMD_CLR_KEY: begin
                                r_klen <= '0; r_kclosed <= 1'b0;
                            end
                            slps_pkg::CMD_CLR_TEXT: r_tlen <= '0;
                            default: ;
                        endcase
                    end
                end
                S_KCHK: begin
                    if (r_i >= r_klen) begin
                        r_front <= '0; r_back <= r_tlen; r_state <= S_BMID;
                    end else r_state <= S_KUSE;
                end
                S_KUSE: begin
                    if (!r_dict || slps_pkg::is_alnum(n_kf)) r_wlen <= r_wlen + 1'b1;
                    if (r_term != 8'd0 && r_kq == r_term) r_i <= r_klen;
                    else r_i <= r_i + 1'b1;
                    r_state <= S_KCHK;
                end
                S_BMID: begin
                    r_p <= n_mid; r_ret <= R_BIS; r_state <= S_SCHK;
                end
                S_SCHK: r_state <= (r_p >= r_back) ? S_SDONE : S_SUSE;
                S_SUSE: begin
                    r_p <= r_p + 1'b1;
                    r_state <= (r_tq == slps_pkg::NEWLINE) ? S_SDONE : S_SCHK;
                end
                S_SDONE: begin
                    if (r_ret == R_LIN) begin
                        r_front <= r_p; r_state <= S_LTOP;
                    end else if (r_p < r_back && r_back > r_front) begin
                        r_lpos <= r_p; r_k <= '0; r_state <= S_CCHK;
                    end else begin
                        r_back <= r_tlen; r_state <= S_LTOP;
                    end
                end
                S_LTOP: begin
                    if (r_front >= r_back) begin
                        r_status <= slps_pkg::ST_NONE; r_state <= S_OUT;
                    end else begin
                        r_p <= r_front; r_k <= '0; r_ret <= R_LIN; r_state <= S_CCHK;
                    end
                end
                S_CCHK: begin
                    if (r_k < r_wlen && r_p < r_back) r_state <= S_CUSE;
                    else begin
                        r_res <= (r_k < r_wlen) ? C_GREATER : C_EQUAL;
                        r_state <= S_CDONE;
                    end
                end
                S_CUSE: begin
                    if (r_tq == slps_pkg::NEWLINE) begin
                        r_res <= C_GREATER; r_state <= S_CDONE;
                    end else if (r_dict && !slps_pkg::is_alnum(n_ch)) begin
                        r_p <= r_p + 1'b1; r_state <= S_CCHK;
                    end else if (r_wq != n_ch) begin
                        r_res <= (r_wq < n_ch) ? C_LESS : C_GREATER;
                        r_state <= S_CDONE;
                    end else begin
                        r_k <= r_k + 1'b1; r_p <= r_p + 1'b1; r_state <= S_CCHK;
                    end
                end
                S_CDONE: begin
                    unique case (r_ret)
                        R_BIS: begin
                            if (r_res == C_GREATER) r_front <= r_lpos;
                            else r_back <= r_lpos;
                            r_state <= S_BMID;
                        end
                        R_LIN: begin
                            if (r_res == C_EQUAL) begin
                                r_first <= r_front; r_count <= '0; r_last <= '0;
                                r_ret <= R_RUN; r_state <= S_RTOP;
                            end else if (r_res == C_LESS) begin
                                r_status <= slps_pkg::ST_NONE; r_state <= S_OUT;
                            end else begin
                                r_p <= r_front; r_state <= S_SCHK;
                            end
                        end
                        R_RUN: begin
                            if (r_res == C_EQUAL) begin
                                r_p <= r_front; r_state <= S_ECHK;
                            end else begin
                                r_status <= slps_pkg::ST_MATCH; r_ms <= 12'(r_first);
                                r_me <= 13'(r_last); r_lc <= 13'(r_count);
                                r_state <= S_OUT;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RTOP: begin
                    if (r_front < r_back) begin
                        r_p <= r_front; r_k <= '0; r_state <= S_CCHK;
                    end else begin
                        r_status <= slps_pkg::ST_MATCH; r_ms <= 12'(r_first);
                        r_me <= 13'(r_last); r_lc <= 13'(r_count);
                        r_state <= S_OUT;
                    end
                end
                S_ECHK: r_state <= (r_p >= r_back) ? S_EDONE : S_EUSE;
                S_EUSE: begin
                    if (r_tq == slps_pkg::NEWLINE) r_state <= S_EDONE;
                    else begin
                        r_p <= r_p + 1'b1; r_state <= S_ECHK;
                    end
                end
                S_EDONE: begin
                    r_count <= r_count + 1'b1; r_last <= r_p;
                    if (r_p >= r_back) begin
                        r_status <= slps_pkg::ST_MATCH; r_ms <= 12'(r_first);
                        r_me <= 13'(r_p); r_lc <= 13'(r_count + 1'b1);
                        r_state <= S_OUT;
                    end else begin
                        r_front <= r_p + 1'b1; r_state <= S_RTOP;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/tb_sorted_line_prefix_search.sv @@
// Self-checking testbench for the sorted line prefix search with a scoreboard class.
`timescale 1ns / 1ps
module tb_sorted_line_prefix_search;
    localparam int TDEPTH = 4096;
    localparam int KDEPTH = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] match_start;
        logic [12:0] match_end;
        logic [12:0] line_count;
    } t_search_result;

    class search_scoreboard;
        byte unsigned text_mem[TDEPTH];
        int           text_len;
        byte unsigned key_mem[KDEPTH];
        int           key_len;
        bit           key_shut;
        bit           fold_en;
        bit           dict_en;
        byte unsigned term_byte;
        byte unsigned work[KDEPTH];
        int           work_len;
        t_search_result awaited_q[$];
        int           errors;

        function new();
            text_len = 0;
            key_len = 0;
            key_shut = 0;
            fold_en = 0;
            dict_en = 0;
            term_byte = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] v);
            if (idx == slps_pkg::REG_FOLD) fold_en = v[0];
            else if (idx == slps_pkg::REG_DICT) dict_en = v[0];
            else if (idx == slps_pkg::REG_TERM) term_byte = v;
        endfunction

        function int lower(int c);
            if (fold_en && c >= 8'h41 && c <= 8'h5A) return c + 32;
            return c;
        endfunction

        function bit alnum(int c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function int line_order(int pos, int back);
            int k;
            int p;
            int ch;
            k = 0;
            p = pos;
            while (k < work_len && p < back && text_mem[p] != slps_pkg::NEWLINE) begin
                ch = lower(text_mem[p]);
                if (dict_en && !alnum(ch)) begin
                    p++;
                end else if (work[k] != ch) begin
                    return (work[k] < ch) ? slps_pkg::CMP_LESS : slps_pkg::CMP_GREATER;
                end else begin
                    k++;
                    p++;
                end
            end
            return (k < work_len) ? slps_pkg::CMP_GREATER : slps_pkg::CMP_EQUAL;
        endfunction

        function int past_line(int p, int back);
            byte unsigned b;
            while (p < back) begin
                b = text_mem[p];
                p++;
                if (b == slps_pkg::NEWLINE) break;
            end
            return p;
        endfunction

        function t_search_result find_run();
            t_search_result r;
            int front, back, p, cnt, last_end, first, c, f, res;
            r = '0;
            work_len = 0;
            for (int i = 0; i < key_len; i++) begin
                c = key_mem[i];
                f = lower(c);
                if (!dict_en || alnum(f)) begin
                    work[work_len] = 8'(f);
                    work_len++;
                end
                if (term_byte != 0 && c == term_byte) break;
            end
            front = 0;
            back = text_len;
            p = past_line(front + (back - front) / 2, back);
            while (p < back && back > front) begin
                if (line_order(p, back) == slps_pkg::CMP_GREATER) front = p;
                else back = p;
                p = past_line(front + (back - front) / 2, back);
            end
            back = text_len;
            forever begin
                if (front >= back) begin
                    r.status = slps_pkg::ST_NONE;
                    return r;
                end
                res = line_order(front, back);
                if (res == slps_pkg::CMP_EQUAL) break;
                if (res == slps_pkg::CMP_LESS) begin
                    r.status = slps_pkg::ST_NONE;
                    return r;
                end
                front = past_line(front, back);
            end
            first = front;
            cnt = 0;
            last_end = 0;
            while (front < back && line_order(front, back) == slps_pkg::CMP_EQUAL) begin
                p = front;
                while (p < back && text_mem[p] != slps_pkg::NEWLINE) p++;
                cnt++;
                last_end = p;
                if (p >= back) break;
                front = p + 1;
            end
            r.status = slps_pkg::ST_MATCH;
            r.match_start = first[11:0];
            r.match_end = last_end[12:0];
            r.line_count = cnt[12:0];
            return r;
        endfunction

        function void note_item(logic [2:0] cmd, logic [7:0] data);
            t_search_result r;
            r = '0;
            r.status = slps_pkg::ST_OK;
            case (cmd)
                slps_pkg::CMD_TEXT: begin
                    if (text_len < TDEPTH) begin
                        text_mem[text_len] = data;
                        text_len++;
                    end else begin
                        r.status = slps_pkg::ST_FULL;
                    end
                end
                slps_pkg::CMD_KEY: begin
                    if (key_shut) begin
                    end else if (data == 0) begin
                        key_shut = 1;
                    end else if (key_len < KDEPTH) begin
                        key_mem[key_len] = data;
                        key_len++;
                    end else begin
                        r.status = slps_pkg::ST_FULL;
                    end
                end
                slps_pkg::CMD_SEARCH: r = find_run();
                slps_pkg::CMD_CLR_KEY: begin
                    key_len = 0;
                    key_shut = 0;
                end
                slps_pkg::CMD_CLR_TEXT: text_len = 0;
                default: ;
            endcase
            awaited_q.push_back(r);
        endfunction

        function void check_result(t_search_result got);
            t_search_result want;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.match_start != want.match_start) begin
                $display("%0t: match_start expected %0d actual %0d", $time,
                         want.match_start, got.match_start);
                errors++;
            end
            if (got.match_end != want.match_end) begin
                $display("%0t: match_end expected %0d actual %0d", $time,
                         want.match_end, got.match_end);
                errors++;
            end
            if (got.line_count != want.line_count) begin
                $display("%0t: line_count expected %0d actual %0d", $time,
                         want.line_count, got.line_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    slps_in_if  in_ch ();
    slps_out_if out_ch ();
    slps_cfg_if cfg_ch ();

    sorted_line_prefix_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    search_scoreboard sb;
    int  quiet_cycles;
    bit  stim_done;
    bit  hold_off;
    string line_q[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [2:0] cmd, logic [7:0] data);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.data <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(cmd, data);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(bit f, bit d, logic [7:0] t);
        drain();
        write_cfg(slps_pkg::REG_FOLD, {7'd0, f});
        write_cfg(slps_pkg::REG_DICT, {7'd0, d});
        write_cfg(slps_pkg::REG_TERM, t);
    endtask

    function automatic byte unsigned rand_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return 8'(8'h61 + $urandom_range(0, 3));
        if (r < 12) return 8'(8'h41 + $urandom_range(0, 3));
        if (r < 14) return 8'(8'h30 + $urandom_range(0, 2));
        if (r == 14) return 8'h2D;
        if (r == 15) return 8'h20;
        if (r == 16) return 8'hE9;
        if (r == 17) return 8'hFF;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic load_text();
        int n;
        string s, tmp;
        line_q.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            s = "";
            for (int j = $urandom_range(0, 5); j > 0; j--) begin
                tmp = " ";
                tmp.putc(0, rand_char());
                if (tmp.getc(0) == slps_pkg::NEWLINE) tmp.putc(0, 8'h61);
                s = {s, tmp};
            end
            line_q.push_back(s);
        end
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && line_q[j] < line_q[j - 1]; j--) begin
                tmp = line_q[j];
                line_q[j] = line_q[j - 1];
                line_q[j - 1] = tmp;
            end
        send_word(slps_pkg::CMD_CLR_TEXT, 8'($urandom));
        foreach (line_q[i]) begin
            for (int j = 0; j < line_q[i].len(); j++)
                send_word(slps_pkg::CMD_TEXT, line_q[i].getc(j));
            if (i < n - 1 || $urandom_range(0, 1)) send_word(slps_pkg::CMD_TEXT, slps_pkg::NEWLINE);
        end
    endtask

    task automatic load_key();
        string s;
        int plen;
        s = line_q[$urandom_range(0, line_q.size() - 1)];
        plen = (s.len() == 0) ? 0 : $urandom_range(0, s.len());
        send_word(slps_pkg::CMD_CLR_KEY, 8'($urandom));
        for (int j = 0; j < plen; j++) begin
            if ($urandom_range(0, 9) == 0) send_word(slps_pkg::CMD_KEY, rand_char());
            else send_word(slps_pkg::CMD_KEY, s.getc(j));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_word(slps_pkg::CMD_KEY, 8'h00);
            send_word(slps_pkg::CMD_KEY, rand_char());
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        stim_done = 0;
        hold_off = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(slps_pkg::CMD_SEARCH, 8'h00);
        send_word(slps_pkg::CMD_KEY, 8'h00);
        send_word(slps_pkg::CMD_KEY, 8'h61);
        send_word(slps_pkg::CMD_SEARCH, 8'hFF);
        send_word(slps_pkg::CMD_CLR_KEY, 8'h00);
        send_word(slps_pkg::CMD_TEXT, 8'h41);
        send_word(slps_pkg::CMD_TEXT, 8'h2D);
        send_word(slps_pkg::CMD_TEXT, 8'h62);
        send_word(slps_pkg::CMD_TEXT, slps_pkg::NEWLINE);
        send_word(slps_pkg::CMD_TEXT, 8'hFF);
        send_word(slps_pkg::CMD_SEARCH, 8'h00);
        send_word(slps_pkg::CMD_KEY, 8'h61);
        send_word(slps_pkg::CMD_KEY, 8'h62);
        send_word(slps_pkg::CMD_SEARCH, 8'h00);
        send_word(slps_pkg::CMD_KEY, 8'hFF);
        send_word(slps_pkg::CMD_SEARCH, 8'h00);
        send_word(3'd5, 8'hAA);
        send_word(3'd6, 8'h55);
        send_word(3'd7, 8'hFF);
        send_word(slps_pkg::CMD_CLR_KEY, 8'h00);
        send_word(slps_pkg::CMD_KEY, 8'h41);
        send_word(slps_pkg::CMD_KEY, 8'h62);
        set_config(1, 1, 8'h41);
        send_word(slps_pkg::CMD_SEARCH, 8'h00);
        send_word(slps_pkg::CMD_CLR_TEXT, 8'h00);
        send_word(slps_pkg::CMD_SEARCH, 8'h00);

        for (int i = 0; i < KDEPTH + 2; i++) send_word(slps_pkg::CMD_KEY, 8'h61);
        send_word(slps_pkg::CMD_CLR_KEY, 8'h00);

        hold_off = 1;
        for (int i = 0; i < 20; i++) send_word(slps_pkg::CMD_TEXT, 8'($urandom));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(0, 0, 8'h00);
                1: set_config(1, 0, 8'hFF);
                2: set_config(0, 1, 8'h00);
                3: set_config(1, 1, 8'h2D);
                default: set_config(1'($urandom), 1'($urandom),
                                    ($urandom_range(0, 1) != 0) ?
                                    8'h00 : 8'(8'h61 + $urandom_range(0, 3)));
            endcase
            for (int s = 0; s < 5; s++) begin
                load_text();
                for (int k = 0; k < 3; k++) begin
                    load_key();
                    send_word(slps_pkg::CMD_SEARCH, 8'($urandom));
                end
                for (int k = $urandom_range(0, 3); k > 0; k--)
                    send_word(3'($urandom_range(0, 7)), 8'($urandom));
            end
        end

        set_config(1, 0, 8'h00);
        send_word(slps_pkg::CMD_CLR_TEXT, 8'h00);
        for (int i = 0; i < 48; i++) begin
            send_word(slps_pkg::CMD_TEXT, 8'(8'h61 + (i / 16) % 4));
            send_word(slps_pkg::CMD_TEXT, 8'(8'h41 + (i / 4) % 4));
            send_word(slps_pkg::CMD_TEXT, 8'(8'h61 + i % 4));
            send_word(slps_pkg::CMD_TEXT, slps_pkg::NEWLINE);
        end
        send_word(slps_pkg::CMD_TEXT, 8'h7A);
        send_word(slps_pkg::CMD_TEXT, 8'h00);
        for (int k = 0; k < 4; k++) begin
            send_word(slps_pkg::CMD_CLR_KEY, 8'h00);
            send_word(slps_pkg::CMD_KEY, 8'(8'h61 + $urandom_range(0, 3)));
            if (k > 1) send_word(slps_pkg::CMD_KEY, 8'(8'h61 + $urandom_range(0, 3)));
            send_word(slps_pkg::CMD_SEARCH, 8'h00);
        end

        drain();
        stim_done = 1;
    end

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                hold_off = 0;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if ($urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.status, out_ch.match_start, out_ch.match_end,
                             out_ch.line_count});
    end

    initial begin
        quiet_cycles = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stim_done) begin
                if (sb.errors == 0 && sb.awaited_q.size() == 0) $display("TEST PASSED");
                else $display("TEST FAILED");
                $finish;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end
endmodule

@@ sorted_line_prefix_search.f @@
rtl/core/slps_pkg.sv
rtl/core/slps_if.sv
rtl/core/sorted_line_prefix_search.sv
tb/tb_sorted_line_prefix_search.sv
